### hdl/assert_macros.svh
// assertion helpers shared by the rtl files
// all of them sample on clk; names clk and rst must exist in the module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define SRL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked during reset as well
`define SRL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/srec_pkg.sv
// ----------------------------------------------------------------------------
// srec_pkg
// shared types and constants of the s-record line checker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package srec_pkg;

  localparam int MAX_LINE_CHARS = 520;
  localparam int POS_W          = 10;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_S  = 8'h53;
  localparam logic [7:0] SUM_GOOD = 8'hFF;

  typedef enum logic [2:0] {
    ERR_NONE  = 3'd0,
    ERR_NO_S  = 3'd1,
    ERR_TYPE  = 3'd2,
    ERR_HEX   = 3'd3,
    ERR_COUNT = 3'd4,
    ERR_SUM   = 3'd5,
    ERR_SHORT = 3'd6,
    ERR_LONG  = 3'd7
  } err_t;

  // classification of one character
  typedef struct packed {
    logic       is_cr;
    logic       is_s;
    logic       is_digit;
    logic       is_hex;
    logic [3:0] nibble;
  } char_class_t;

  // outcome of the line that a carriage return closes
  typedef struct packed {
    logic line_ok;
    err_t code;
  } line_result_t;

endpackage

### hdl/srec_line_checker.sv
// ----------------------------------------------------------------------------
// srec_line_checker
// checks motorola s-record lines one character word at a time
// ----------------------------------------------------------------------------
// usage:
//   char channel: character with char_valid / char_ready, one ascii word per
//     accepted handshake, a line runs from 'S' to carriage return
//   result channel: line_ok and error_code with result_valid / result_ready,
//     exactly one word per carriage return, none for other characters
// timing:
//   a word is registered on acceptance and folded into the line state as it
//   leaves the input register; a carriage-return verdict is loaded into the
//   result register as that word leaves the input register
//   throughput is one character word per cycle while no carriage return is
//   stalled; the line state updates between the input and result registers
// stall:
//   while a verdict waits in the result register a further carriage return
//   holds in the input register and char_ready drops; other characters keep
//   flowing since they give no result
// reset:
//   rst clears the line state and both valid flags, so the first word after
//   reset starts a fresh line
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module srec_line_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_ready,
  input  logic [7:0] character,
  output logic       result_valid,
  input  logic       result_ready,
  output logic       line_ok,
  output logic [2:0] error_code
);

  // input register
  logic       stage_valid;
  logic [7:0] stage_char;

  srec_pkg::char_class_t  cls;
  srec_pkg::line_result_t verdict;
  srec_pkg::line_result_t result;

  // the held word moves on unless it is a carriage return with no room
  logic advance;

  assign advance    = stage_valid && (!cls.is_cr || !result_valid || result_ready);
  assign char_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (char_ready) begin
      stage_valid <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_ready && char_valid) stage_char <= character;
  end

  srec_char_decode u_decode (
    .character (stage_char),
    .cls       (cls)
  );

  srec_line_state u_state (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .cls    (cls),
    .result (verdict)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && cls.is_cr) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && cls.is_cr) result <= verdict;
  end

  assign line_ok    = result.line_ok;
  assign error_code = result.code;

  `SRL_ASSERT_ALWAYS(a_reset_empty, rst |=> !result_valid, "result valid after reset")
  `SRL_ASSERT(a_ok_match, result_valid |-> (line_ok == (error_code == srec_pkg::ERR_NONE)), "line_ok disagrees with code")
  `SRL_ASSERT(a_cr_hold, (stage_valid && cls.is_cr && result_valid && !result_ready) |=> (stage_valid && cls.is_cr), "carriage return lost while result stalled")

endmodule

### hdl/srec_char_decode.sv
// ----------------------------------------------------------------------------
// srec_char_decode
// classifies one ascii character and gives its hex nibble value
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srec_char_decode (
  input  logic [7:0]                character,
  output srec_pkg::char_class_t     cls
);

  always_comb begin
    cls          = '0;
    cls.is_cr    = (character == srec_pkg::CH_CR);
    cls.is_s     = (character == srec_pkg::CH_S);
    cls.is_digit = (character inside {[8'h30:8'h39]});
    if (character inside {[8'h30:8'h39]}) begin
      cls.is_hex = 1'b1;
      cls.nibble = character[3:0];
    end else if (character inside {[8'h41:8'h46]}) begin
      cls.is_hex = 1'b1;
      cls.nibble = 4'(character[3:0] + 4'd9);
    end
  end

endmodule

### hdl/srec_line_state.sv
// ----------------------------------------------------------------------------
// srec_line_state
// running line state and the end-of-line verdict
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module srec_line_state (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  srec_pkg::char_class_t      cls,
  output srec_pkg::line_result_t     result
);

  localparam logic [srec_pkg::POS_W-1:0] POS_MAX =
    srec_pkg::POS_W'(srec_pkg::MAX_LINE_CHARS);

  logic [srec_pkg::POS_W-1:0] position, position_next;
  logic [3:0]                 high_nibble, high_nibble_next;
  logic [7:0]                 count_field, count_field_next;
  logic [7:0]                 byte_sum, byte_sum_next;
  srec_pkg::err_t             first_error, first_error_next;

  logic [7:0]                 byte_val;
  logic [srec_pkg::POS_W-1:0] len_m4;
  srec_pkg::err_t             verdict;

  assign byte_val = {high_nibble, cls.nibble};
  assign len_m4   = position - srec_pkg::POS_W'(4);

  // next line state
  always_comb begin
    position_next    = position;
    high_nibble_next = high_nibble;
    count_field_next = count_field;
    byte_sum_next    = byte_sum;
    first_error_next = first_error;
    if (cls.is_cr) begin
      position_next    = '0;
      high_nibble_next = '0;
      count_field_next = '0;
      byte_sum_next    = '0;
      first_error_next = srec_pkg::ERR_NONE;
    end else if (position >= POS_MAX) begin
      if (first_error == srec_pkg::ERR_NONE) first_error_next = srec_pkg::ERR_LONG;
    end else begin
      if (position == '0) begin
        if (!cls.is_s && first_error == srec_pkg::ERR_NONE)
          first_error_next = srec_pkg::ERR_NO_S;
      end else if (position == srec_pkg::POS_W'(1)) begin
        if (!cls.is_digit && first_error == srec_pkg::ERR_NONE)
          first_error_next = srec_pkg::ERR_TYPE;
      end else begin
        if (!cls.is_hex && first_error == srec_pkg::ERR_NONE)
          first_error_next = srec_pkg::ERR_HEX;
        if (!position[0]) begin
          high_nibble_next = cls.nibble;
        end else begin
          if (position == srec_pkg::POS_W'(3)) count_field_next = byte_val;
          byte_sum_next = byte_sum + byte_val;
        end
      end
      position_next = position + srec_pkg::POS_W'(1);
    end
  end

  // verdict for a carriage return seen in the current state
  always_comb begin
    if (first_error != srec_pkg::ERR_NONE)
      verdict = first_error;
    else if (position == '0)
      verdict = srec_pkg::ERR_NO_S;
    else if (position == srec_pkg::POS_W'(1))
      verdict = srec_pkg::ERR_TYPE;
    else if (position < srec_pkg::POS_W'(4) || position[0])
      verdict = srec_pkg::ERR_SHORT;
    else if ({1'b0, count_field} != len_m4[srec_pkg::POS_W-1:1])
      verdict = srec_pkg::ERR_COUNT;
    else if (byte_sum != srec_pkg::SUM_GOOD)
      verdict = srec_pkg::ERR_SUM;
    else
      verdict = srec_pkg::ERR_NONE;
  end

  assign result.code    = verdict;
  assign result.line_ok = (verdict == srec_pkg::ERR_NONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      position    <= '0;
      high_nibble <= '0;
      count_field <= '0;
      byte_sum    <= '0;
      first_error <= srec_pkg::ERR_NONE;
    end else if (step) begin
      position    <= position_next;
      high_nibble <= high_nibble_next;
      count_field <= count_field_next;
      byte_sum    <= byte_sum_next;
      first_error <= first_error_next;
    end
  end

  `SRL_ASSERT(a_pos_bound, position <= POS_MAX, "line position beyond limit")

endmodule
